@@ hw/rtl/lpxd_pkg.sv @@
// lpxd_pkg: shared types and constants of the length-prefixed xor deframer
// used by lpxd_core and length_prefixed_xor_deframer; no dependencies
package lpxd_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic REG_KEY_SEED = 1'b0;

    // key advances by these bits of each plain byte
    localparam logic [7:0] KEY_STEP_MASK = 8'h03;

    typedef struct packed {
        logic [7:0]  plain_byte;
        logic [15:0] packet_length;
        logic        end_of_packet;
        logic        empty_packet;
    } t_result;

endpackage

@@ hw/rtl/lpxd_core.sv @@
// lpxd_core: framing state machine and payload descrambler, one byte per step
// depends on lpxd_pkg
module lpxd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_key_seed,
    output logic                o_has_result,
    output lpxd_pkg::t_result   o_result
);

    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_length_low,  n_length_low;
    logic [15:0] r_cur_len,     n_cur_len;
    logic [15:0] r_bytes_left,  n_bytes_left;
    logic [7:0]  r_key,         n_key;

    logic [7:0]  plain;
    logic [15:0] len_full;
    logic [15:0] bytes_dec;

    assign plain     = i_byte ^ r_key;
    assign len_full  = {i_byte, r_length_low};
    assign bytes_dec = r_bytes_left - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_length_low = r_length_low;
        n_cur_len    = r_cur_len;
        n_bytes_left = r_bytes_left;
        n_key        = r_key;
        o_has_result = 1'b0;
        o_result     = '0;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_cur_len = len_full;
                n_key     = i_key_seed;
                if (len_full == 16'd0) begin
                    // empty packet: single empty result
                    n_bytes_left           = 16'd0;
                    n_phase                = PH_LEN_LO;
                    o_has_result           = 1'b1;
                    o_result.end_of_packet = 1'b1;
                    o_result.empty_packet  = 1'b1;
                end else begin
                    n_bytes_left = len_full;
                    n_phase      = PH_DATA;
                end
            end
            PH_DATA: begin
                n_key                  = r_key + (plain & lpxd_pkg::KEY_STEP_MASK);
                n_bytes_left           = bytes_dec;
                o_has_result           = 1'b1;
                o_result.plain_byte    = plain;
                o_result.packet_length = r_cur_len;
                o_result.end_of_packet = (bytes_dec == 16'd0);
                if (bytes_dec == 16'd0) begin
                    n_phase = PH_LEN_LO;
                end
            end
            default: begin
                // first length byte, unused code too
                n_length_low = i_byte;
                n_phase      = PH_LEN_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN_LO;
            r_length_low <= 8'd0;
            r_cur_len    <= 16'd0;
            r_bytes_left <= 16'd0;
            r_key        <= 8'd0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_length_low <= n_length_low;
            r_cur_len    <= n_cur_len;
            r_bytes_left <= n_bytes_left;
            r_key        <= n_key;
        end
    end

endmodule

@@ hw/rtl/length_prefixed_xor_deframer.sv @@
// length_prefixed_xor_deframer: top level, input register, result register, apb seed
// depends on lpxd_pkg and lpxd_core
//
// channel   dir  handshake                     payload
// s (rx)    in   i_s_tvalid / o_s_tready       i_s_tdata = rx_byte
// m (out)   out  o_m_tvalid / i_m_tready       o_m_tdata, o_m_tlast, o_m_tuser
// apb       in   i_psel / i_penable / o_pready key_seed at byte address 0
//
// one item per clock sustained while results are taken; an item waits in the input register,
// then is framed and descrambled in a single pass into the result register
// a result passes through the input register and then the result register to the m side
// synchronous active-low reset clears control and returns framing to the first length byte
// a stalled result holds the register; bytes that give no result still drain behind it,
// a byte that gives a result waits in the input register until the result is taken
module length_prefixed_xor_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // rx byte stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [23:0]                     o_m_tdata,   // [7:0] plain_byte, [23:8] packet_length
    output logic                            o_m_tlast,   // end_of_packet
    output logic [0:0]                      o_m_tuser,   // [0] empty_packet
    // apb configuration
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [lpxd_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [lpxd_pkg::PDATA_W-1:0]    i_pwdata,
    output logic [lpxd_pkg::PDATA_W-1:0]    o_prdata,
    output logic                            o_pready
);

    logic [7:0]        r_key_seed;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    lpxd_pkg::t_result r_out;

    logic              has_result;
    lpxd_pkg::t_result result;
    logic              advance;
    logic              out_free;
    logic              seed_wr;

    // apb: single register, always ready
    assign o_pready = 1'b1;
    assign seed_wr  = i_psel && i_penable && i_pwrite
                      && (i_paddr[2] == lpxd_pkg::REG_KEY_SEED);
    assign o_prdata = (i_paddr[2] == lpxd_pkg::REG_KEY_SEED)
                      ? {{(lpxd_pkg::PDATA_W-8){1'b0}}, r_key_seed}
                      : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_seed <= 8'd0;
        end else if (seed_wr) begin
            r_key_seed <= i_pwdata[7:0];
        end
    end

    // result register frees up when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    // bytes that give no result never wait on the output side
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    lpxd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_key_seed   (r_key_seed),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {r_out.packet_length, r_out.plain_byte};
    assign o_m_tlast    = r_out.end_of_packet;
    assign o_m_tuser[0] = r_out.empty_packet;

endmodule

@@ hw/rtl/lpxd_checker.sv @@
// lpxd_checker: port-level assertions for the deframer, bound to the top level
// depends on length_prefixed_xor_deframer
module lpxd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [0:0]  o_m_tuser,
    input logic        o_pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // empty packet result is last and carries zero byte and length
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast && (o_m_tdata == 24'd0))
        else $error("malformed empty packet result");

    // payload results always belong to a packet of nonzero length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata[23:8] != 16'd0))
        else $error("payload result with zero length");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready dropped");

endmodule

bind length_prefixed_xor_deframer lpxd_checker u_lpxd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser),
    .o_pready   (o_pready)
);

@@ bench/tb.sv @@
// tb: self-checking bench for length_prefixed_xor_deframer, the framing and key
// schedule are mirrored in the bench and every result is compared field by field
// depends on lpxd_pkg and the rtl of length_prefixed_xor_deframer
module tb;

    // slack after the last due result; the block has an input register and a result register
    localparam int SETTLE_CYCLES  = 8;
    // cycles without any handshake before the run is given up
    localparam int QUIET_LIMIT    = 4000;
    // random bytes per idling phase
    localparam int PHASE_BYTES    = 475;
    localparam int MAX_REPORTS    = 10;
    localparam int unsigned ADDR_W = lpxd_pkg::PADDR_W;

    // byte addresses of the seed register and of an index past the register list
    localparam logic [ADDR_W-1:0] ADDR_KEY_SEED =
        ADDR_W'(4 * int'(lpxd_pkg::REG_KEY_SEED));
    localparam logic [ADDR_W-1:0] ADDR_SPARE    =
        ADDR_W'(4 * (int'(lpxd_pkg::REG_KEY_SEED) + 1));

    // framing position of the mirrored deframer
    typedef enum logic [1:0] {
        AWAIT_LEN_LO = 2'd0,
        AWAIT_LEN_HI = 2'd1,
        IN_PAYLOAD   = 2'd2
    } t_frame_pos;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata  = '0;   // [7:0] rx_byte
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [23:0]                     o_m_tdata;         // [7:0] plain_byte, [23:8] packet_length
    logic                            o_m_tlast;         // end_of_packet
    logic [0:0]                      o_m_tuser;         // [0] empty_packet
    logic                            i_psel     = 1'b0;
    logic                            i_penable  = 1'b0;
    logic                            i_pwrite   = 1'b0;
    logic [ADDR_W-1:0]               i_paddr    = '0;
    logic [lpxd_pkg::PDATA_W-1:0]    i_pwdata   = '0;
    logic [lpxd_pkg::PDATA_W-1:0]    o_prdata;
    logic                            o_pready;

    length_prefixed_xor_deframer dut (.*);

    always #10 i_clk = ~i_clk;

    // bytes waiting to be offered, and descrambled results still owed by the block
    logic [7:0]        pending_bytes[$];
    lpxd_pkg::t_result due_results[$];

    // idling profile of the current phase, in percent
    int send_idle_pct = 0;
    int stall_pct     = 0;

    int error_count = 0;
    int quiet_count = 0;

    // mirrored deframer state
    t_frame_pos  frame_pos   = AWAIT_LEN_LO;
    logic [7:0]  len_low     = '0;
    logic [15:0] pkt_len     = '0;
    logic [15:0] pkt_left    = '0;
    logic [7:0]  key_now     = '0;
    logic [7:0]  seed_mirror = '0;

    // random stream generator, keeps its place in a packet across phases
    t_frame_pos  gen_pos  = AWAIT_LEN_LO;
    logic [15:0] gen_len  = '0;
    logic [15:0] gen_left = '0;

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endtask

    // one received byte through the framing and key schedule
    function automatic void descramble_byte(input logic [7:0] b, output bit emitted,
                                            output lpxd_pkg::t_result r);
        logic [7:0] plain;
        emitted = 1'b0;
        r = '0;
        case (frame_pos)
            AWAIT_LEN_HI: begin
                pkt_len = {b, len_low};
                // the key restarts here, so a seed written mid-packet waits
                key_now = seed_mirror;
                if (pkt_len == 16'd0) begin
                    // empty packet: one result flagged empty, plain byte held at zero
                    pkt_left = '0;
                    frame_pos = AWAIT_LEN_LO;
                    r.end_of_packet = 1'b1;
                    r.empty_packet  = 1'b1;
                    emitted = 1'b1;
                end else begin
                    pkt_left = pkt_len;
                    frame_pos = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD: begin
                plain = b ^ key_now;
                key_now = key_now + (plain & lpxd_pkg::KEY_STEP_MASK);
                pkt_left = pkt_left - 16'd1;
                r.plain_byte    = plain;
                r.packet_length = pkt_len;
                r.end_of_packet = (pkt_left == 16'd0);
                if (pkt_left == 16'd0)
                    frame_pos = AWAIT_LEN_LO;
                emitted = 1'b1;
            end
            default: begin
                // first length byte, any stray code behaves the same
                len_low = b;
                frame_pos = AWAIT_LEN_HI;
            end
        endcase
    endfunction

    // rx driver: offers queued bytes, holds a byte until it is taken
    always @(posedge i_clk) begin : drive_rx
        bit                emitted;
        lpxd_pkg::t_result r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                descramble_byte(i_s_tdata, emitted, r);
                if (emitted)
                    due_results.push_back(r);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_bytes.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: each taken item against the oldest due result
    always @(posedge i_clk) begin : check_results
        lpxd_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("unexpected item", 32'd0,
                                  {6'd0, o_m_tuser, o_m_tlast, o_m_tdata});
                end else begin
                    want = due_results.pop_front();
                    if (o_m_tdata[7:0] !== want.plain_byte)
                        flag_mismatch("plain_byte", 32'(want.plain_byte),
                                      32'(o_m_tdata[7:0]));
                    if (o_m_tdata[23:8] !== want.packet_length)
                        flag_mismatch("packet_length", 32'(want.packet_length),
                                      32'(o_m_tdata[23:8]));
                    if (o_m_tlast !== want.end_of_packet)
                        flag_mismatch("end_of_packet", 32'(want.end_of_packet),
                                      32'(o_m_tlast));
                    if (o_m_tuser[0] !== want.empty_packet)
                        flag_mismatch("empty_packet", 32'(want.empty_packet),
                                      32'(o_m_tuser[0]));
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog: any handshake on any port counts as progress
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (i_psel && i_penable))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        // register takes the value at this edge
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        if (addr == ADDR_KEY_SEED)
            seed_mirror = data[7:0];
    endtask

    // read back the seed; sampled at the edge that ends the access cycle
    task automatic check_seed_readback();
        logic [31:0] got;
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= ADDR_KEY_SEED;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        got = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        if (got !== {24'd0, seed_mirror})
            flag_mismatch("key_seed readback", {24'd0, seed_mirror}, got);
    endtask

    // block drained: nothing queued, nothing offered, nothing owed, then settle
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_s_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_header(input logic [15:0] len);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(len[15:8]);
    endtask

    // random packet stream, mostly short packets with the odd long one
    task automatic push_stream(input int count);
        int pick;
        repeat (count) begin
            case (gen_pos)
                AWAIT_LEN_HI: begin
                    pending_bytes.push_back(gen_len[15:8]);
                    gen_left = gen_len;
                    gen_pos  = (gen_len == 16'd0) ? AWAIT_LEN_LO : IN_PAYLOAD;
                end
                IN_PAYLOAD: begin
                    pending_bytes.push_back(8'($urandom));
                    gen_left = gen_left - 16'd1;
                    if (gen_left == 16'd0)
                        gen_pos = AWAIT_LEN_LO;
                end
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        gen_len = 16'd0;
                    else if (pick < 70)
                        gen_len = 16'($urandom_range(1, 8));
                    else if (pick < 95)
                        gen_len = 16'($urandom_range(9, 40));
                    else
                        gen_len = 16'($urandom_range(256, 300));
                    pending_bytes.push_back(gen_len[7:0]);
                    gen_pos = AWAIT_LEN_HI;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int phase_idle[4];
        int phase_stall[4];
        logic [7:0] phase_seed[4];

        phase_idle  = '{0, 88, 0, 9};
        phase_stall = '{0, 0, 88, 9};
        phase_seed  = '{8'($urandom_range(1, 254)), 8'hFF, 8'h00, 8'($urandom)};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seed of zero, then a write past the register list must change nothing
        check_seed_readback();
        apb_write(ADDR_SPARE, $urandom);
        check_seed_readback();

        // directed, seed zero: empty packet, single bytes at both extremes
        push_header(16'd0);
        push_header(16'd1);
        pending_bytes.push_back(8'h00);
        push_header(16'd1);
        pending_bytes.push_back(8'hFF);
        wait_idle();

        // directed, seed all ones: key carried along a packet, empty packet in between
        apb_write(ADDR_KEY_SEED, 32'h0000_00FF);
        check_seed_readback();
        push_header(16'd3);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h5A);
        push_header(16'd0);
        push_header(16'd2);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'hFF);
        wait_idle();

        // random phases; each ends wherever the stream happens to be, so the
        // seed is often rewritten mid-packet or between the two length bytes
        for (int p = 0; p < 4; p++) begin
            apb_write(ADDR_KEY_SEED, {24'd0, phase_seed[p]});
            if ($urandom_range(0, 1) == 1)
                apb_write(ADDR_SPARE, $urandom);
            check_seed_readback();
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            push_stream(PHASE_BYTES);
            wait_idle();
        end

        if (error_count == 0 && due_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ length_prefixed_xor_deframer.f @@
hw/rtl/lpxd_pkg.sv
hw/rtl/lpxd_core.sv
hw/rtl/length_prefixed_xor_deframer.sv
hw/rtl/lpxd_checker.sv
bench/tb.sv
